// File: rtl/rfb_pkg.sv
package rfb_pkg;

  typedef enum logic [2:0] {
    CMD_REG_WRITE = 3'd0,
    CMD_REG_READ  = 3'd1,
    CMD_VAR_WRITE = 3'd2,
    CMD_VAR_READ  = 3'd3,
    CMD_DATA      = 3'd4
  } rfb_cmd_e;

  localparam logic [7:0] BYTE_REG_WRITE = 8'h80;
  localparam logic [7:0] BYTE_REG_READ  = 8'h81;
  localparam logic [7:0] BYTE_VAR_WRITE = 8'h82;
  localparam logic [7:0] BYTE_VAR_READ  = 8'h83;

  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Byte slots of a frame, in send order; a job is a mask over them.
  localparam int unsigned NumSlots = 12;
  localparam int unsigned SLOT_H1   = 0;
  localparam int unsigned SLOT_H2   = 1;
  localparam int unsigned SLOT_LEN  = 2;
  localparam int unsigned SLOT_CMD  = 3;
  localparam int unsigned SLOT_AHI  = 4;
  localparam int unsigned SLOT_ALO  = 5;
  localparam int unsigned SLOT_CNT  = 6;
  localparam int unsigned SLOT_DHI  = 7;
  localparam int unsigned SLOT_DLO  = 8;
  localparam int unsigned SLOT_CRCH = 9;
  localparam int unsigned SLOT_CRCL = 10;
  localparam int unsigned SLOT_MIS  = 11;

  typedef logic [NumSlots-1:0] rfb_mask_t;

  // Slots whose bytes feed the CRC
  localparam rfb_mask_t CRC_COVER = rfb_mask_t'((1 << SLOT_CMD) | (1 << SLOT_AHI) |
                                                (1 << SLOT_ALO) | (1 << SLOT_CNT) |
                                                (1 << SLOT_DHI) | (1 << SLOT_DLO));

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic       crc_en;
  } rfb_cfg_t;

  typedef struct packed {
    rfb_mask_t   mask;
    logic        close;
    logic [7:0]  cmd_byte;
    logic [7:0]  len_byte;
    logic [15:0] address;
    logic [7:0]  count;
    logic [15:0] data;
  } rfb_job_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic       misuse_flag;
  } rfb_result_t;

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/rfb_fifo.sv
module rfb_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/rfb_front.sv
module rfb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rfb_pkg::rfb_cfg_t cfg_i,
  input  logic              take_i,
  input  logic [2:0]        command_i,
  input  logic [15:0]       address_i,
  input  logic [7:0]        count_i,
  input  logic [15:0]       data_i,
  output rfb_pkg::rfb_job_t job_o
);

  logic       frame_open_q, frame_open_d;
  logic       word_elem_q, word_elem_d;
  logic [7:0] left_q, left_d;

  logic [1:0] extra;
  logic [8:0] reg_len;
  logic [9:0] var_len;
  logic [7:0] left_dec;
  logic       bad;
  rfb_pkg::rfb_mask_t crc_tail;

  assign extra    = {cfg_i.crc_en, 1'b0};
  assign reg_len  = {1'b0, count_i} + 9'd2 + 9'(extra);
  assign var_len  = {1'b0, count_i, 1'b1} + 10'd2 + 10'(extra);
  assign left_dec = left_q - 8'd1;
  assign crc_tail = cfg_i.crc_en ?
                    rfb_pkg::rfb_mask_t'((1 << rfb_pkg::SLOT_CRCH) | (1 << rfb_pkg::SLOT_CRCL)) :
                    '0;

  always_comb begin
    job_o          = '0;
    job_o.address  = address_i;
    job_o.count    = count_i;
    job_o.data     = data_i;
    frame_open_d   = frame_open_q;
    word_elem_d    = word_elem_q;
    left_d         = left_q;
    bad            = 1'b0;

    unique case (command_i)
      rfb_pkg::CMD_REG_WRITE: begin
        bad            = frame_open_q || (reg_len > 9'd255);
        job_o.cmd_byte = rfb_pkg::BYTE_REG_WRITE;
        job_o.len_byte = reg_len[7:0];
        job_o.close    = (count_i == 8'd0);
        job_o.mask     = rfb_pkg::rfb_mask_t'((1 << rfb_pkg::SLOT_H1) | (1 << rfb_pkg::SLOT_H2) |
                         (1 << rfb_pkg::SLOT_LEN) | (1 << rfb_pkg::SLOT_CMD) |
                         (1 << rfb_pkg::SLOT_ALO)) | (job_o.close ? crc_tail : '0);
        frame_open_d   = (count_i != 8'd0);
        word_elem_d    = 1'b0;
        left_d         = count_i;
      end
      rfb_pkg::CMD_REG_READ: begin
        bad            = frame_open_q;
        job_o.cmd_byte = rfb_pkg::BYTE_REG_READ;
        job_o.len_byte = 8'd3 + 8'(extra);
        job_o.close    = 1'b1;
        job_o.mask     = rfb_pkg::rfb_mask_t'((1 << rfb_pkg::SLOT_H1) | (1 << rfb_pkg::SLOT_H2) |
                         (1 << rfb_pkg::SLOT_LEN) | (1 << rfb_pkg::SLOT_CMD) |
                         (1 << rfb_pkg::SLOT_ALO) | (1 << rfb_pkg::SLOT_CNT)) | crc_tail;
      end
      rfb_pkg::CMD_VAR_WRITE: begin
        bad            = frame_open_q || (var_len > 10'd255);
        job_o.cmd_byte = rfb_pkg::BYTE_VAR_WRITE;
        job_o.len_byte = var_len[7:0];
        job_o.close    = (count_i == 8'd0);
        job_o.mask     = rfb_pkg::rfb_mask_t'((1 << rfb_pkg::SLOT_H1) | (1 << rfb_pkg::SLOT_H2) |
                         (1 << rfb_pkg::SLOT_LEN) | (1 << rfb_pkg::SLOT_CMD) |
                         (1 << rfb_pkg::SLOT_AHI) | (1 << rfb_pkg::SLOT_ALO)) |
                         (job_o.close ? crc_tail : '0);
        frame_open_d   = (count_i != 8'd0);
        word_elem_d    = 1'b1;
        left_d         = count_i;
      end
      rfb_pkg::CMD_VAR_READ: begin
        bad            = frame_open_q;
        job_o.cmd_byte = rfb_pkg::BYTE_VAR_READ;
        job_o.len_byte = 8'd4 + 8'(extra);
        job_o.close    = 1'b1;
        job_o.mask     = rfb_pkg::rfb_mask_t'((1 << rfb_pkg::SLOT_H1) | (1 << rfb_pkg::SLOT_H2) |
                         (1 << rfb_pkg::SLOT_LEN) | (1 << rfb_pkg::SLOT_CMD) |
                         (1 << rfb_pkg::SLOT_AHI) | (1 << rfb_pkg::SLOT_ALO) |
                         (1 << rfb_pkg::SLOT_CNT)) | crc_tail;
      end
      rfb_pkg::CMD_DATA: begin
        bad          = !frame_open_q;
        job_o.close  = (left_dec == 8'd0);
        job_o.mask   = rfb_pkg::rfb_mask_t'(1 << rfb_pkg::SLOT_DLO) |
                       (word_elem_q ? rfb_pkg::rfb_mask_t'(1 << rfb_pkg::SLOT_DHI) : '0) |
                       (job_o.close ? crc_tail : '0);
        frame_open_d = !job_o.close;
        left_d       = left_dec;
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    // reject: one zero word with the flag, state untouched
    if (bad) begin
      job_o.mask   = rfb_pkg::rfb_mask_t'(1 << rfb_pkg::SLOT_MIS);
      job_o.close  = 1'b0;
      frame_open_d = frame_open_q;
      word_elem_d  = word_elem_q;
      left_d       = left_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      word_elem_q  <= 1'b0;
      left_q       <= '0;
    end else if (take_i) begin
      frame_open_q <= frame_open_d;
      word_elem_q  <= word_elem_d;
      left_q       <= left_d;
    end
  end

endmodule

// File: rtl/rfb_back.sv
module rfb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rfb_pkg::rfb_cfg_t    cfg_i,
  input  logic                 job_valid_i,
  input  rfb_pkg::rfb_job_t    job_i,
  output logic                 job_take_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output rfb_pkg::rfb_result_t res_o
);

  rfb_pkg::rfb_job_t  cur_q, cur_d;
  logic               busy_q, busy_d;
  logic [15:0]        crc_q, crc_d;
  rfb_pkg::rfb_mask_t pick, rest;
  logic [7:0]         slot_byte [rfb_pkg::NumSlots];
  logic [7:0]         sel_byte;
  logic               last_slot;

  assign pick      = cur_q.mask & (~cur_q.mask + 1'b1);
  assign rest      = cur_q.mask & ~pick;
  assign last_slot = (rest == '0);

  always_comb begin
    slot_byte[rfb_pkg::SLOT_H1]   = cfg_i.header_first;
    slot_byte[rfb_pkg::SLOT_H2]   = cfg_i.header_second;
    slot_byte[rfb_pkg::SLOT_LEN]  = cur_q.len_byte;
    slot_byte[rfb_pkg::SLOT_CMD]  = cur_q.cmd_byte;
    slot_byte[rfb_pkg::SLOT_AHI]  = cur_q.address[15:8];
    slot_byte[rfb_pkg::SLOT_ALO]  = cur_q.address[7:0];
    slot_byte[rfb_pkg::SLOT_CNT]  = cur_q.count;
    slot_byte[rfb_pkg::SLOT_DHI]  = cur_q.data[15:8];
    slot_byte[rfb_pkg::SLOT_DLO]  = cur_q.data[7:0];
    slot_byte[rfb_pkg::SLOT_CRCH] = crc_q[15:8];
    slot_byte[rfb_pkg::SLOT_CRCL] = crc_q[7:0];
    slot_byte[rfb_pkg::SLOT_MIS]  = 8'h00;
    sel_byte = '0;
    for (int i = 0; i < rfb_pkg::NumSlots; i++) begin
      sel_byte = sel_byte | (pick[i] ? slot_byte[i] : 8'h00);
    end
  end

  always_comb begin
    res_push_o        = busy_q && !res_full_i;
    res_o.out_byte    = sel_byte;
    res_o.run_last    = last_slot;
    res_o.frame_end   = last_slot && cur_q.close;
    res_o.misuse_flag = pick[rfb_pkg::SLOT_MIS];

    // load the next job when idle or when this word finishes the current one
    job_take_o = job_valid_i && (!busy_q || (res_push_o && last_slot));

    cur_d  = cur_q;
    busy_d = busy_q;
    crc_d  = crc_q;
    if (res_push_o) begin
      cur_d.mask = rest;
      busy_d     = !last_slot;
      if (pick[rfb_pkg::SLOT_H1]) begin
        crc_d = '0;
      end else if ((pick & rfb_pkg::CRC_COVER) != '0) begin
        crc_d = rfb_pkg::crc_update(crc_q, sel_byte);
      end
    end
    if (job_take_o) begin
      cur_d  = job_i;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      crc_q  <= '0;
    end else begin
      busy_q <= busy_d;
      crc_q  <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

// File: rtl/register_frame_builder_crc16_top.sv
// Channel   Handshake          Payload
// input     push / full        command_i, address_i, count_i, data_i
// result    empty / pop        out_byte_o, run_last_o, frame_end_o, misuse_flag_o
// config    cfg_we_i           cfg_index_i, cfg_data_i (0 hdr1, 1 hdr2, 2 crc enable)
//
// Each item yields 1 to 9 frame bytes; the byte sequencer in the back part sends
// one byte per cycle while the result queue has room.
// The CRC is folded in a byte per cycle alongside the sequencer, stalling with it.
// The front accepts an item in the cycle it is offered while the job queue has room.
// Either side may stall; job and result queues absorb the difference.
// Reset clears frame state, the CRC and all queues; config returns to 0x5A, 0xA5, 1.
module register_frame_builder_crc16_top #(
  parameter int unsigned JobDepth = 2,
  parameter int unsigned ResDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  count_i,
  input  logic [15:0] data_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        frame_end_o,
  output logic        misuse_flag_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam logic [1:0] RegHdr1  = 2'd0;
  localparam logic [1:0] RegHdr2  = 2'd1;
  localparam logic [1:0] RegCrcEn = 2'd2;

  rfb_pkg::rfb_cfg_t    cfg_q;
  rfb_pkg::rfb_job_t    job_in, job_out;
  rfb_pkg::rfb_result_t res_in, res_out;
  logic                 take, job_empty, job_take, res_full, res_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= 8'h5A;
      cfg_q.header_second <= 8'hA5;
      cfg_q.crc_en        <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegHdr1:  cfg_q.header_first  <= cfg_data_i;
        RegHdr2:  cfg_q.header_second <= cfg_data_i;
        RegCrcEn: cfg_q.crc_en        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign take = push && !full;

  rfb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .take_i    (take),
    .command_i (command_i),
    .address_i (address_i),
    .count_i   (count_i),
    .data_i    (data_i),
    .job_o     (job_in)
  );

  rfb_fifo #(
    .Width ($bits(rfb_pkg::rfb_job_t)),
    .Depth (JobDepth)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .wdata_i (job_in),
    .full_o  (full),
    .pop_i   (job_take),
    .rdata_o (job_out),
    .empty_o (job_empty)
  );

  rfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (!job_empty),
    .job_i       (job_out),
    .job_take_o  (job_take),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  rfb_fifo #(
    .Width ($bits(rfb_pkg::rfb_result_t)),
    .Depth (ResDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign out_byte_o    = res_out.out_byte;
  assign run_last_o    = res_out.run_last;
  assign frame_end_o   = res_out.frame_end;
  assign misuse_flag_o = res_out.misuse_flag;

endmodule

// File: dv/frame_byte_checker.sv
`timescale 1ns / 100ps

package frame_tb_pkg;

  localparam logic [1:0] REG_HDR_FIRST  = 2'd0;
  localparam logic [1:0] REG_HDR_SECOND = 2'd1;
  localparam logic [1:0] REG_CRC_EN     = 2'd2;

  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  localparam int unsigned MaxFrameBytes = 9;

endpackage

module frame_byte_checker
  import rfb_pkg::*, frame_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  count_i,
  input  logic [15:0] data_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte_i,
  input  logic        run_last_i,
  input  logic        frame_end_i,
  input  logic        misuse_flag_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int unsigned errors_o,
  output int unsigned bytes_due_o
);

  logic [7:0]  hdr_first;
  logic [7:0]  hdr_second;
  logic        crc_on;

  logic        wr_open;
  logic        wide_data;
  logic [7:0]  elems_left;
  logic [15:0] frame_crc;

  rfb_result_t frame_bytes [MaxFrameBytes];
  int unsigned n_frame_bytes;
  rfb_result_t bytes_due_q [$];

  // Reflected CRC, one message bit per step, LSB first
  function automatic logic [15:0] crc16_arc_step(logic [15:0] acc, logic [7:0] b);
    logic fb;
    int   k;
    for (k = 0; k < 8; k++) begin
      fb  = acc[0] ^ b[k];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  task automatic emit(input logic [7:0] b, input logic covered, input logic closes);
    if (covered) begin
      frame_crc = crc16_arc_step(frame_crc, b);
    end
    frame_bytes[n_frame_bytes].out_byte    = b;
    frame_bytes[n_frame_bytes].run_last    = 1'b0;
    frame_bytes[n_frame_bytes].frame_end   = closes;
    frame_bytes[n_frame_bytes].misuse_flag = 1'b0;
    n_frame_bytes++;
  endtask

  task automatic emit_header(input logic [7:0] len);
    frame_crc = '0;
    emit(hdr_first, 1'b0, 1'b0);
    emit(hdr_second, 1'b0, 1'b0);
    emit(len, 1'b0, 1'b0);
  endtask

  // crc_on is looked at again here, not only when the length byte went out
  task automatic close_frame_bytes();
    logic [15:0] crc_sent;
    crc_sent = frame_crc;
    if (crc_on) begin
      emit(crc_sent[15:8], 1'b0, 1'b0);
      emit(crc_sent[7:0], 1'b0, 1'b1);
    end else if (n_frame_bytes > 0) begin
      frame_bytes[n_frame_bytes-1].frame_end = 1'b1;
    end
    wr_open    = 1'b0;
    elems_left = '0;
  endtask

  task automatic build_frame_bytes(input logic [2:0] cmd, input logic [15:0] addr,
                                   input logic [7:0] cnt, input logic [15:0] dat);
    int unsigned tail;
    logic        rejected;
    rfb_result_t misuse;
    tail          = crc_on ? 2 : 0;
    n_frame_bytes = 0;
    case (cmd)
      CMD_DATA:                   rejected = !wr_open;
      CMD_REG_READ, CMD_VAR_READ: rejected = wr_open;
      CMD_REG_WRITE:              rejected = wr_open || (int'(cnt) + 2 + tail > 255);
      CMD_VAR_WRITE:              rejected = wr_open || (2 * int'(cnt) + 3 + tail > 255);
      default:                    rejected = 1'b1;
    endcase

    if (rejected) begin
      misuse.out_byte    = 8'h00;
      misuse.run_last    = 1'b1;
      misuse.frame_end   = 1'b0;
      misuse.misuse_flag = 1'b1;
      bytes_due_q.push_back(misuse);
    end else begin
      case (cmd)
        CMD_REG_WRITE: begin
          emit_header(8'(int'(cnt) + 2 + tail));
          emit(BYTE_REG_WRITE, 1'b1, 1'b0);
          emit(addr[7:0], 1'b1, 1'b0);
          wr_open    = 1'b1;
          wide_data  = 1'b0;
          elems_left = cnt;
          if (cnt == 0) begin
            close_frame_bytes();
          end
        end
        CMD_REG_READ: begin
          emit_header(8'(3 + tail));
          emit(BYTE_REG_READ, 1'b1, 1'b0);
          emit(addr[7:0], 1'b1, 1'b0);
          emit(cnt, 1'b1, 1'b0);
          close_frame_bytes();
        end
        CMD_VAR_WRITE: begin
          emit_header(8'(2 * int'(cnt) + 3 + tail));
          emit(BYTE_VAR_WRITE, 1'b1, 1'b0);
          emit(addr[15:8], 1'b1, 1'b0);
          emit(addr[7:0], 1'b1, 1'b0);
          wr_open    = 1'b1;
          wide_data  = 1'b1;
          elems_left = cnt;
          if (cnt == 0) begin
            close_frame_bytes();
          end
        end
        CMD_VAR_READ: begin
          emit_header(8'(4 + tail));
          emit(BYTE_VAR_READ, 1'b1, 1'b0);
          emit(addr[15:8], 1'b1, 1'b0);
          emit(addr[7:0], 1'b1, 1'b0);
          emit(cnt, 1'b1, 1'b0);
          close_frame_bytes();
        end
        default: begin
          if (wide_data) begin
            emit(dat[15:8], 1'b1, 1'b0);
          end
          emit(dat[7:0], 1'b1, 1'b0);
          elems_left = elems_left - 8'd1;
          if (elems_left == 0) begin
            close_frame_bytes();
          end
        end
      endcase
      frame_bytes[n_frame_bytes-1].run_last = 1'b1;
      for (int i = 0; i < n_frame_bytes; i++) begin
        bytes_due_q.push_back(frame_bytes[i]);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rfb_result_t want;
    rfb_result_t got;
    if (!rst_ni) begin
      hdr_first  = 8'h5A;
      hdr_second = 8'hA5;
      crc_on     = 1'b1;
      wr_open    = 1'b0;
      wide_data  = 1'b0;
      elems_left = '0;
      frame_crc  = '0;
      bytes_due_q.delete();
      errors_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_HDR_FIRST:  hdr_first  = cfg_data_i;
          REG_HDR_SECOND: hdr_second = cfg_data_i;
          REG_CRC_EN:     crc_on     = cfg_data_i[0];
          default: ;
        endcase
      end

      if (push && !full) begin
        build_frame_bytes(command_i, address_i, count_i, data_i);
      end

      if (pop && !empty) begin
        got.out_byte    = out_byte_i;
        got.run_last    = run_last_i;
        got.frame_end   = frame_end_i;
        got.misuse_flag = misuse_flag_i;
        if (bytes_due_q.size() == 0) begin
          $display("%0t: word with none due: byte %h last %b end %b misuse %b", $time,
                   got.out_byte, got.run_last, got.frame_end, got.misuse_flag);
          errors_o++;
        end else begin
          want = bytes_due_q.pop_front();
          if (got !== want) begin
            $display("%0t: expected byte %h last %b end %b misuse %b, got %h %b %b %b",
                     $time, want.out_byte, want.run_last, want.frame_end, want.misuse_flag,
                     got.out_byte, got.run_last, got.frame_end, got.misuse_flag);
            errors_o++;
          end
        end
      end
    end
    bytes_due_o = bytes_due_q.size();
  end

endmodule

// File: dv/register_frame_builder_crc16_top_tb.sv
`timescale 1ns / 100ps

module register_frame_builder_crc16_top_tb;
  import rfb_pkg::*;
  import frame_tb_pkg::*;

  localparam int unsigned ClkHigh     = 4;
  localparam int unsigned ClkLow      = 4;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned ItemTarget  = 310;
  localparam int unsigned LongFrame   = 125;
  // counts that no crc setting can make legal
  localparam int unsigned RegCountNeverOk = 254;
  localparam int unsigned VarCountNeverOk = 127;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  logic [2:0]  command_i   = '0;
  logic [15:0] address_i   = '0;
  logic [7:0]  count_i     = '0;
  logic [15:0] data_i      = '0;
  logic        empty;
  logic        pop         = 1'b0;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        frame_end_o;
  logic        misuse_flag_o;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i  = '0;

  int unsigned errors;
  int unsigned bytes_due;
  int unsigned items_sent = 0;
  int unsigned stalled    = 0;
  logic        calm       = 1'b0;
  logic        hold_req   = 1'b0;

  always begin
    #(ClkLow) clk_i = 1'b1;
    #(ClkHigh) clk_i = 1'b0;
  end

  register_frame_builder_crc16_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .address_i    (address_i),
    .count_i      (count_i),
    .data_i       (data_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .frame_end_o  (frame_end_o),
    .misuse_flag_o(misuse_flag_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  frame_byte_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .address_i    (address_i),
    .count_i      (count_i),
    .data_i       (data_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_i   (out_byte_o),
    .run_last_i   (run_last_o),
    .frame_end_i  (frame_end_o),
    .misuse_flag_i(misuse_flag_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (errors),
    .bytes_due_o  (bytes_due)
  );

  // Mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] rand8();
    return 8'($urandom);
  endfunction

  task automatic send_word(input logic [2:0] cmd, input logic [15:0] addr,
                           input logic [7:0] cnt, input logic [15:0] dat);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push      <= 1'b1;
    command_i <= cmd;
    address_i <= addr;
    count_i   <= cnt;
    data_i    <= dat;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (bytes_due != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] h1, input logic [7:0] h2, input logic [7:0] crc);
    wait_drained();
    write_reg(REG_HDR_FIRST, h1);
    write_reg(REG_HDR_SECOND, h2);
    write_reg(REG_CRC_EN, crc);
  endtask

  // Whole frames with random content, plus the odd rejected word
  task automatic random_burst();
    int unsigned pick;
    int unsigned n;
    logic [2:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      op = $urandom_range(0, 1) ? CMD_VAR_WRITE : CMD_REG_WRITE;
      n  = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 4);
      send_word(op, rand16(), 8'(n), rand16());
      repeat (n) begin
        if ($urandom_range(0, 15) == 0) begin
          send_word(3'($urandom_range(CMD_REG_WRITE, CMD_VAR_READ)), rand16(), rand8(),
                    rand16());
        end
        send_word(CMD_DATA, rand16(), rand8(), rand16());
      end
    end else if (pick < 80) begin
      op = $urandom_range(0, 1) ? CMD_VAR_READ : CMD_REG_READ;
      send_word(op, rand16(), rand8(), rand16());
    end else if (pick < 88) begin
      send_word(CMD_DATA, rand16(), rand8(), rand16());
    end else if (pick < 94) begin
      send_word(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), rand16(), rand8(), rand16());
    end else if ($urandom_range(0, 1)) begin
      send_word(CMD_REG_WRITE, rand16(), 8'($urandom_range(RegCountNeverOk, 255)), rand16());
    end else begin
      send_word(CMD_VAR_WRITE, rand16(), 8'($urandom_range(VarCountNeverOk, 255)), rand16());
    end
  endtask

  // Receiver side: random pop gaps, and one long hold on request
  initial begin : result_drain
    int unsigned rest;
    rest = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (rest > 0) begin
        pop <= 1'b0;
        rest--;
      end else begin
        pop  <= 1'b1;
        rest = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stalled <= 0;
    end else if (stalled >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // field extremes under reset config
    send_word(CMD_REG_READ, 16'hFFFF, 8'h00, 16'h0000);
    send_word(CMD_VAR_READ, 16'h0000, 8'hFF, 16'hFFFF);
    send_word(CMD_VAR_READ, 16'hA5C3, 8'h5A, 16'h0000);
    // zero-count writes close at once
    send_word(CMD_REG_WRITE, 16'h3412, 8'h00, 16'h0000);
    send_word(CMD_VAR_WRITE, 16'hFFFF, 8'h00, 16'hFFFF);
    // data with nothing open, unknown commands
    send_word(CMD_DATA, 16'h0000, 8'h00, 16'hFFFF);
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) begin
      send_word(3'(c), rand16(), rand8(), rand16());
    end
    // one past the count limit with crc, and the top count
    send_word(CMD_REG_WRITE, 16'h00AA, 8'd252, 16'h0000);
    send_word(CMD_VAR_WRITE, 16'h55AA, 8'd126, 16'h0000);
    send_word(CMD_REG_WRITE, 16'h0000, 8'hFF, 16'h0000);
    // opens while a write is still waiting for data
    send_word(CMD_REG_WRITE, 16'h00C3, 8'd2, 16'h0000);
    send_word(CMD_REG_READ, 16'h0011, 8'd4, 16'h0000);
    send_word(CMD_VAR_WRITE, 16'h2222, 8'd1, 16'h0000);
    send_word(CMD_VAR_READ, 16'h3333, 8'd2, 16'h0000);
    send_word(CMD_DATA, 16'h0000, 8'h00, 16'h00FF);
    send_word(CMD_DATA, 16'h0000, 8'h00, 16'hFF00);
    send_word(CMD_VAR_WRITE, 16'h8001, 8'd1, 16'h0000);
    send_word(CMD_DATA, 16'h0000, 8'h00, 16'hFFFF);
    // drop crc between the length byte and the close
    send_word(CMD_VAR_WRITE, 16'h1234, 8'd1, 16'h0000);
    wait_drained();
    write_reg(REG_CRC_EN, 8'h00);
    send_word(CMD_DATA, 16'h0000, 8'h00, 16'hBEEF);

    // longest legal word frame while the receiver holds off
    set_config(8'h5A, 8'hA5, 8'h01);
    send_word(CMD_VAR_WRITE, rand16(), 8'(LongFrame), rand16());
    hold_req = 1'b1;
    repeat (LongFrame) send_word(CMD_DATA, rand16(), rand8(), rand16());
    while (items_sent < 175) random_burst();

    set_config(8'h00, 8'h00, 8'h00);
    send_word(CMD_REG_WRITE, rand16(), 8'(RegCountNeverOk), rand16());
    send_word(CMD_VAR_WRITE, rand16(), 8'(VarCountNeverOk), rand16());
    while (items_sent < 220) random_burst();

    // no idling on either side
    set_config(8'hFF, 8'hFF, 8'h01);
    calm = 1'b1;
    while (items_sent < 265) random_burst();
    calm = 1'b0;

    set_config(rand8(), rand8(), rand8());
    while (items_sent < ItemTarget) random_burst();

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (errors == 0 && bytes_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
